FILE: design/svie_pkg.sv
package svie_pkg;

  // Storage sizes
  localparam int RegCount   = 16;
  localparam int StackDepth = 256;
  localparam int HeapDepth  = 256;

  localparam int RegAw   = $clog2(RegCount);
  localparam int StackAw = $clog2(StackDepth);
  localparam int HeapAw  = $clog2(HeapDepth);

  // Reset sweep covers the deeper of the two memories
  localparam int ClrDepth = (StackDepth > HeapDepth) ? StackDepth : HeapDepth;
  localparam int ClrAw    = $clog2(ClrDepth);

  // Architectural register indexes
  localparam logic [RegAw-1:0] RegIp  = RegAw'(0);
  localparam logic [RegAw-1:0] RegSp  = RegAw'(1);
  localparam logic [RegAw-1:0] RegFp  = RegAw'(2);
  localparam logic [RegAw-1:0] RegA   = RegAw'(3);
  localparam logic [RegAw-1:0] RegB   = RegAw'(4);
  localparam logic [RegAw-1:0] RegRop = RegAw'(5);
  localparam logic [RegAw-1:0] RegEf  = RegAw'(6);

  typedef enum logic [3:0] {
    FN_NOP  = 4'd0,
    FN_ADD  = 4'd1,
    FN_SUB  = 4'd2,
    FN_MULT = 4'd3,
    FN_CMP  = 4'd4,
    FN_MOV  = 4'd5,
    FN_JMP  = 4'd6,
    FN_JNZ  = 4'd7,
    FN_JZ   = 4'd8,
    FN_PUSH = 4'd9,
    FN_POP  = 4'd10,
    FN_CALL = 4'd11,
    FN_RET  = 4'd12,
    FN_HALT = 4'd13
  } func_e;

  typedef enum logic [2:0] {
    MD_DIRECT = 3'd0,
    MD_REG    = 3'd1,
    MD_HEAP   = 3'd2,
    MD_FRAME  = 3'd3,
    MD_SP     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_OP1,
    ST_OP2,
    ST_EX
  } state_e;

endpackage

FILE: design/svie_if.sv
interface svie_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic [2:0]         mode_first;
  logic signed [15:0] value_first;
  logic [2:0]         mode_second;
  logic signed [15:0] value_second;

  modport source (output valid, func, mode_first, value_first, mode_second, value_second,
                  input ready);
  modport sink (input valid, func, mode_first, value_first, mode_second, value_second,
                output ready);
endinterface

interface svie_rsp_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_address;
  logic signed [15:0] result_value;
  logic               halted;

  modport source (output valid, next_address, result_value, halted, input ready);
  modport sink (input valid, next_address, result_value, halted, output ready);
endinterface

interface svie_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_address;

  modport source (output valid, start_address, input ready);
  modport sink (input valid, start_address, output ready);
endinterface

FILE: design/svie_alu.sv
module svie_alu (
  input  logic [3:0]  func_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [15:0] res_o
);
  import svie_pkg::*;

  logic [31:0] prod;

  assign prod = 32'(a_i) * 32'(b_i);

  // Wrap every result at 16 bits
  always_comb begin
    unique case (func_i)
      FN_ADD:  res_o = 16'(a_i + b_i);
      FN_SUB:  res_o = 16'(a_i - b_i);
      FN_MULT: res_o = prod[15:0];
      FN_CMP:  res_o = {15'd0, (a_i == b_i)};
      default: res_o = 16'd0;
    endcase
  end
endmodule

FILE: design/stack_vm_instruction_execute.sv
// Instruction execute stage of a small 16-bit stack machine.
//
// req_i carries one fetched instruction per request: opcode plus two operands,
// each with an addressing mode. rsp_o returns one response per request with
// the next instruction address, the result register and the halted flag.
// cfg_i writes start_address, which is copied into the instruction pointer;
// it is always ready and is meant to be used while no request is in flight.
//
// Each instruction passes through ST_OP1, ST_OP2 and ST_EX: issue the first
// operand's memory read, issue the second one while capturing the first, then
// execute and write back, as the stack and heap memories each have a single
// read and write port. The next request is taken in the execute cycle of the
// current one, so it is accepted before the current one has finished. A
// finished response sits in an output register; a stalled receiver holds the
// current instruction in its execute cycle only while that register is full.
//
// After reset both memories are swept to zero, one entry per cycle, over all
// 256 entries; requests are not taken during the sweep. Once the halt flag
// is set, requests are still answered but change nothing.
module stack_vm_instruction_execute (
  input logic          clk_i,
  input logic          rst_ni,
  svie_req_if.sink     req_i,
  svie_rsp_if.source   rsp_o,
  svie_cfg_if.sink     cfg_i
);
  import svie_pkg::*;

  state_e state_q, state_d;

  logic [ClrAw-1:0] clr_q;
  logic             clr_last;
  logic             stack_clr_en;
  logic             heap_clr_en;

  // Request buffer
  logic        in_full_q;
  logic [3:0]  func_q;
  logic [2:0]  m1_q, m2_q;
  logic [15:0] v1_q, v2_q;
  logic        take;
  logic        fire;

  // Register file and memories
  logic [15:0] regs_q [RegCount];
  logic [15:0] regs_d [RegCount];
  logic [15:0] stack_mem [StackDepth];
  logic [15:0] heap_mem  [HeapDepth];
  logic [15:0] stack_rd_q, heap_rd_q;
  logic [15:0] a_q;

  // Output register
  logic        out_valid_q;
  logic [15:0] out_addr_q, out_res_q;
  logic        out_halt_q;

  logic        running;
  logic        is_ret, is_arith;
  logic [2:0]  em1, em2, ph_m, val_m;
  logic [15:0] ev1, ev2, ph_v, val_v;
  logic [15:0] ph_base, ph_sum;
  logic [15:0] rd_val;
  logic [15:0] alu_res;
  logic [15:0] target;
  logic [15:0] dst_base, dst_sum;
  logic        adv;

  logic                stack_we;
  logic [StackAw-1:0]  stack_waddr;
  logic [15:0]         stack_wdata;
  logic                heap_we;
  logic [HeapAw-1:0]   heap_waddr;
  logic [15:0]         heap_wdata;

  assign running  = (regs_q[RegEf] == 16'd0);
  assign is_ret   = (func_q == FN_RET);
  assign is_arith = (func_q == FN_ADD) || (func_q == FN_SUB) ||
                    (func_q == FN_MULT) || (func_q == FN_CMP);

  // Return reads its two saved words below the frame pointer
  assign em1 = is_ret ? MD_FRAME : m1_q;
  assign ev1 = is_ret ? 16'hFFFE : v1_q;
  assign em2 = is_ret ? MD_FRAME : m2_q;
  assign ev2 = is_ret ? 16'hFFFF : v2_q;

  // Read address for the operand being issued this cycle
  assign ph_m    = (state_q == ST_OP1) ? em1 : em2;
  assign ph_v    = (state_q == ST_OP1) ? ev1 : ev2;
  assign ph_base = (ph_m == MD_SP) ? regs_q[RegSp] : regs_q[RegFp];
  assign ph_sum  = 16'(ph_base + ph_v);

  // Operand whose value arrives this cycle
  assign val_m = (state_q == ST_OP2) ? em1 : em2;
  assign val_v = (state_q == ST_OP2) ? ev1 : ev2;

  always_comb begin
    case (val_m)
      MD_REG:          rd_val = regs_q[val_v[RegAw-1:0]];
      MD_HEAP:         rd_val = heap_rd_q;
      MD_FRAME, MD_SP: rd_val = stack_rd_q;
      default:         rd_val = val_v;
    endcase
  end

  svie_alu u_alu (
    .func_i (func_q),
    .a_i    (a_q),
    .b_i    (rd_val),
    .res_o  (alu_res)
  );

  assign target   = (m1_q != MD_DIRECT) ? v1_q : 16'(regs_q[RegIp] + v1_q);
  assign dst_base = (m1_q == MD_SP) ? regs_q[RegSp] : regs_q[RegFp];
  assign dst_sum  = 16'(dst_base + v1_q);

  assign clr_last     = (clr_q == ClrAw'(ClrDepth - 1));
  assign stack_clr_en = ({1'b0, clr_q} < (ClrAw + 1)'(StackDepth));
  assign heap_clr_en  = ({1'b0, clr_q} < (ClrAw + 1)'(HeapDepth));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_OP1;
      ST_OP1:   if (in_full_q) state_d = ST_OP2;
      ST_OP2:   state_d = ST_EX;
      ST_EX:    if (!out_valid_q || rsp_o.ready) state_d = ST_OP1;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    fire = 1'b0;
    unique case (state_q)
      ST_EX:   fire = !out_valid_q || rsp_o.ready;
      default: fire = 1'b0;
    endcase
  end

  assign req_i.ready = (state_q != ST_CLEAR) && (!in_full_q || fire);
  assign take        = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Register file update in instruction order
  always_comb begin
    regs_d = regs_q;
    adv    = 1'b1;
    if (state_q == ST_OP2 && running && (is_arith || func_q == FN_PUSH)) begin
      regs_d[RegA] = rd_val;
    end
    if (fire && running) begin
      case (func_q)
        FN_ADD, FN_SUB, FN_MULT, FN_CMP: begin
          regs_d[RegB]   = rd_val;
          regs_d[RegRop] = alu_res;
        end
        FN_MOV: begin
          regs_d[RegB] = rd_val;
          if (m1_q == MD_REG) regs_d[v1_q[RegAw-1:0]] = rd_val;
        end
        FN_JMP: begin
          regs_d[RegIp] = target;
          adv           = 1'b0;
        end
        FN_JNZ: begin
          if (regs_q[RegRop] != 16'd0) begin
            regs_d[RegIp] = target;
            adv           = 1'b0;
          end
        end
        FN_JZ: begin
          if (regs_q[RegRop] == 16'd0) begin
            regs_d[RegIp] = target;
            adv           = 1'b0;
          end
        end
        FN_PUSH: regs_d[RegSp] = 16'(regs_q[RegSp] + 16'd1);
        FN_POP:  regs_d[RegSp] = 16'(regs_q[RegSp] - 16'd1);
        FN_CALL: begin
          regs_d[RegSp] = 16'(regs_q[RegSp] + 16'd2);
          regs_d[RegFp] = 16'(regs_q[RegSp] + 16'd2);
          regs_d[RegIp] = target;
          adv           = 1'b0;
        end
        FN_RET: begin
          regs_d[RegSp] = regs_q[RegFp];
          regs_d[RegIp] = a_q;
          regs_d[RegFp] = rd_val;
        end
        FN_HALT: regs_d[RegEf] = 16'd1;
        default: ;
      endcase
      if (adv) regs_d[RegIp] = 16'(regs_d[RegIp] + 16'd1);
    end
    if (cfg_i.valid && cfg_i.ready) regs_d[RegIp] = cfg_i.start_address;
  end

  // Stack write port: sweep, saved return address, then execute writes
  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = clr_q[StackAw-1:0];
    stack_wdata = 16'd0;
    if (state_q == ST_CLEAR) begin
      stack_we = stack_clr_en;
    end else if (state_q == ST_OP1 && in_full_q && running && func_q == FN_CALL) begin
      stack_we    = 1'b1;
      stack_waddr = regs_q[RegSp][StackAw-1:0];
      stack_wdata = regs_q[RegIp];
    end else if (fire && running) begin
      case (func_q)
        FN_PUSH: begin
          stack_we    = 1'b1;
          stack_waddr = regs_q[RegSp][StackAw-1:0];
          stack_wdata = a_q;
        end
        FN_CALL: begin
          stack_we    = 1'b1;
          stack_waddr = StackAw'(regs_q[RegSp] + 16'd1);
          stack_wdata = regs_q[RegFp];
        end
        FN_MOV: begin
          stack_we    = (m1_q == MD_FRAME) || (m1_q == MD_SP);
          stack_waddr = dst_sum[StackAw-1:0];
          stack_wdata = rd_val;
        end
        default: ;
      endcase
    end
  end

  // Heap write port
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = clr_q[HeapAw-1:0];
    heap_wdata = 16'd0;
    if (state_q == ST_CLEAR) begin
      heap_we = heap_clr_en;
    end else if (fire && running && func_q == FN_MOV && m1_q == MD_HEAP) begin
      heap_we    = 1'b1;
      heap_waddr = v1_q[HeapAw-1:0];
      heap_wdata = rd_val;
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    stack_rd_q <= stack_mem[ph_sum[StackAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    heap_rd_q <= heap_mem[ph_v[HeapAw-1:0]];
  end

  // Control state and register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RegCount; i++) regs_q[i] <= 16'd0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= ClrAw'(clr_q + 1'b1);
      if (take) in_full_q <= 1'b1;
      else if (fire) in_full_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
      regs_q <= regs_d;
    end
  end

  // Payload: request buffer, first operand, response
  always_ff @(posedge clk_i) begin
    if (take) begin
      func_q <= req_i.func;
      m1_q   <= req_i.mode_first;
      v1_q   <= req_i.value_first;
      m2_q   <= req_i.mode_second;
      v2_q   <= req_i.value_second;
    end
    if (state_q == ST_OP2) a_q <= rd_val;
    if (fire) begin
      out_addr_q <= regs_d[RegIp];
      out_res_q  <= regs_d[RegRop];
      out_halt_q <= (regs_d[RegEf] != 16'd0);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.next_address = out_addr_q;
  assign rsp_o.result_value = out_res_q;
  assign rsp_o.halted       = out_halt_q;

endmodule

FILE: design/svie_checker.sv
module svie_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic rsp_halted_i
);
  logic [1:0] pending_q;
  logic       halted_seen_q;

  // Track requests in flight and whether a halt has been reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= 2'd0;
      halted_seen_q <= 1'b0;
    end else begin
      pending_q <= 2'(pending_q + {1'b0, req_valid_i && req_ready_i}
                             - {1'b0, rsp_valid_i && rsp_ready_i});
      if (rsp_valid_i && rsp_ready_i && rsp_halted_i) halted_seen_q <= 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_no_extra_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i |-> pending_q != 2'd0)
    else $error("response without request");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd2 && !rsp_ready_i |-> !req_ready_i)
    else $error("request taken with buffer and output full");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_seen_q && rsp_valid_i |-> rsp_halted_i)
    else $error("halt flag cleared after halt");

endmodule

bind stack_vm_instruction_execute svie_checker u_svie_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_halted_i (rsp_o.halted)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import svie_pkg::*;

  typedef struct packed {
    logic [3:0]  fn;
    logic [2:0]  m1;
    logic [15:0] v1;
    logic [2:0]  m2;
    logic [15:0] v2;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_address;
    logic [15:0] result_value;
    logic        halted;
  } status_t;

  // Opcodes without a name in the package
  localparam logic [3:0] FnSpare14 = 4'd14;
  localparam logic [3:0] FnSpare15 = 4'd15;
  localparam int         WatchdogLimit = 4000;
  localparam int         LongHold      = 90;
  localparam int         PhaseItems    = 120;

  // Idle plans for the phases
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_plan_e;

  logic clk_i;
  logic rst_ni;

  svie_req_if req_ch ();
  svie_rsp_if rsp_ch ();
  svie_cfg_if cfg_ch ();

  stack_vm_instruction_execute u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  // Machine state mirror
  logic [15:0] vm_regs  [RegCount];
  logic [15:0] vm_stack [StackDepth];
  logic [15:0] vm_heap  [HeapDepth];

  instr_t     pending_instrs [$];
  status_t    expected_status [$];
  instr_t     in_flight;
  idle_plan_e idle_plan;
  logic       long_hold_phase;
  int         mismatches;
  int         instrs_sent;
  int         status_seen;
  int         cfg_writes;

  // Clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [15:0] fetch_operand(logic [2:0] mode, logic [15:0] v);
    logic [15:0] addr;
    case (mode)
      MD_REG: fetch_operand = vm_regs[v[RegAw-1:0]];
      MD_HEAP: fetch_operand = vm_heap[v[HeapAw-1:0]];
      MD_FRAME: begin
        addr = vm_regs[RegFp] + v;
        fetch_operand = vm_stack[addr[StackAw-1:0]];
      end
      MD_SP: begin
        addr = vm_regs[RegSp] + v;
        fetch_operand = vm_stack[addr[StackAw-1:0]];
      end
      default: fetch_operand = v;
    endcase
  endfunction

  function automatic void store_operand(logic [2:0] mode, logic [15:0] v, logic [15:0] x);
    logic [15:0] addr;
    case (mode)
      MD_REG: vm_regs[v[RegAw-1:0]] = x;
      MD_HEAP: vm_heap[v[HeapAw-1:0]] = x;
      MD_FRAME: begin
        addr = vm_regs[RegFp] + v;
        vm_stack[addr[StackAw-1:0]] = x;
      end
      MD_SP: begin
        addr = vm_regs[RegSp] + v;
        vm_stack[addr[StackAw-1:0]] = x;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] branch_target(logic [2:0] mode, logic [15:0] v);
    branch_target = (mode != MD_DIRECT) ? v : vm_regs[RegIp] + v;
  endfunction

  // Execute one instruction on the mirror and queue the status it yields
  function automatic void execute_instr(instr_t it);
    logic        advance;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] sp;
    logic [15:0] fp;
    logic [15:0] addr;
    status_t     st;
    advance = 1'b1;
    if (vm_regs[RegEf] == 16'd0) begin
      case (it.fn)
        FN_ADD, FN_SUB, FN_MULT, FN_CMP: begin
          vm_regs[RegA] = fetch_operand(it.m1, it.v1);
          vm_regs[RegB] = fetch_operand(it.m2, it.v2);
          a = vm_regs[RegA];
          b = vm_regs[RegB];
          case (it.fn)
            FN_ADD:  vm_regs[RegRop] = a + b;
            FN_SUB:  vm_regs[RegRop] = a - b;
            FN_MULT: vm_regs[RegRop] = a * b;
            default: vm_regs[RegRop] = {15'd0, a == b};
          endcase
        end
        FN_MOV: begin
          vm_regs[RegB] = fetch_operand(it.m2, it.v2);
          store_operand(it.m1, it.v1, vm_regs[RegB]);
        end
        FN_JMP: begin
          vm_regs[RegIp] = branch_target(it.m1, it.v1);
          advance = 1'b0;
        end
        FN_JNZ: if (vm_regs[RegRop] != 16'd0) begin
          vm_regs[RegIp] = branch_target(it.m1, it.v1);
          advance = 1'b0;
        end
        FN_JZ: if (vm_regs[RegRop] == 16'd0) begin
          vm_regs[RegIp] = branch_target(it.m1, it.v1);
          advance = 1'b0;
        end
        FN_PUSH: begin
          vm_regs[RegA] = fetch_operand(it.m1, it.v1);
          sp = vm_regs[RegSp];
          vm_stack[sp[StackAw-1:0]] = vm_regs[RegA];
          vm_regs[RegSp] = sp + 16'd1;
        end
        FN_POP: vm_regs[RegSp] = vm_regs[RegSp] - 16'd1;
        FN_CALL: begin
          sp = vm_regs[RegSp];
          vm_stack[sp[StackAw-1:0]] = vm_regs[RegIp];
          addr = sp + 16'd1;
          vm_stack[addr[StackAw-1:0]] = vm_regs[RegFp];
          vm_regs[RegSp] = sp + 16'd2;
          vm_regs[RegFp] = vm_regs[RegSp];
          vm_regs[RegIp] = branch_target(it.m1, it.v1);
          advance = 1'b0;
        end
        FN_RET: begin
          fp = vm_regs[RegFp];
          vm_regs[RegSp] = fp;
          addr = fp - 16'd2;
          vm_regs[RegIp] = vm_stack[addr[StackAw-1:0]];
          addr = fp - 16'd1;
          vm_regs[RegFp] = vm_stack[addr[StackAw-1:0]];
        end
        FN_HALT: vm_regs[RegEf] = 16'd1;
        default: ;
      endcase
      if (advance) vm_regs[RegIp] = vm_regs[RegIp] + 16'd1;
    end
    st.next_address = vm_regs[RegIp];
    st.result_value = vm_regs[RegRop];
    st.halted       = (vm_regs[RegEf] != 16'd0);
    expected_status.push_back(st);
  endfunction

  function automatic instr_t make_instr(logic [3:0] fn, logic [2:0] m1, logic [15:0] v1,
                                       logic [2:0] m2, logic [15:0] v2);
    make_instr = '{fn: fn, m1: m1, v1: v1, m2: m2, v2: v2};
  endfunction

  // Random instruction that never halts the machine
  function automatic instr_t random_instr();
    instr_t it;
    it.fn = 4'($urandom_range(0, 15));
    if (it.fn == FN_HALT) it.fn = FN_NOP;
    it.m1 = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    it.m2 = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    it.v1 = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    it.v2 = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    // Keep the halt flag register clear
    if (it.fn == FN_MOV && it.m1 == MD_REG && it.v1[RegAw-1:0] == RegEf) it.v1[0] = 1'b1;
    return it;
  endfunction

  // Queue a subroutine frame: call, a short body, return
  task automatic queue_call_frame();
    int body;
    body = $urandom_range(1, 4);
    pending_instrs.push_back(make_instr(FN_CALL, 3'($urandom_range(0, 4)),
                                        16'($urandom), MD_DIRECT, 16'd0));
    repeat (body) begin
      if ($urandom_range(0, 1) == 0)
        pending_instrs.push_back(make_instr(FN_PUSH, 3'($urandom_range(0, 4)),
                                            16'($urandom_range(0, 8)), MD_DIRECT, 16'd0));
      else
        pending_instrs.push_back(make_instr(4'($urandom_range(1, 4)), MD_FRAME,
                                            16'($urandom_range(0, 3)), MD_SP,
                                            16'hFFFF - 16'($urandom_range(0, 3))));
    end
    pending_instrs.push_back(make_instr(FN_RET, MD_DIRECT, 16'd0, MD_DIRECT, 16'd0));
  endtask

  task automatic queue_random_phase(int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_call_frame();
        n = n + 4;
      end else begin
        pending_instrs.push_back(random_instr());
        n = n + 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_instrs.size() != 0 || expected_status.size() != 0 || req_ch.valid)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the start address while the machine is idle
  task automatic write_start(logic [15:0] addr);
    wait_drained();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.start_address <= addr;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    vm_regs[RegIp] = addr;
    cfg_writes++;
  endtask

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        execute_instr(in_flight);
        instrs_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_instrs.size() != 0 &&
            !((idle_plan == IDLE_SENDER && $urandom_range(0, 99) < 68) ||
              (idle_plan == IDLE_BOTH && $urandom_range(0, 99) < 21))) begin
          in_flight = pending_instrs.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.func         <= in_flight.fn;
          req_ch.mode_first   <= in_flight.m1;
          req_ch.value_first  <= in_flight.v1;
          req_ch.mode_second  <= in_flight.m2;
          req_ch.value_second <= in_flight.v2;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver stalls
  int  hold_cnt;
  logic hold_done;
  always @(posedge clk_i) begin
    status_t exp;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt     = 0;
      hold_done    = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        status_seen++;
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response ip=%h rop=%h halted=%b",
                                         rsp_ch.next_address, rsp_ch.result_value,
                                         rsp_ch.halted);
        end else begin
          exp = expected_status.pop_front();
          if (rsp_ch.next_address !== exp.next_address ||
              rsp_ch.result_value !== exp.result_value || rsp_ch.halted !== exp.halted) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response %0d: expected ip=%h rop=%h halted=%b, got ip=%h rop=%h halted=%b",
                       status_seen, exp.next_address, exp.result_value, exp.halted,
                       rsp_ch.next_address, rsp_ch.result_value, rsp_ch.halted);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ch.ready <= 1'b0;
      end else if (long_hold_phase && !hold_done) begin
        hold_cnt  = LongHold;
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !((idle_plan == IDLE_RECEIVER && $urandom_range(0, 99) < 68) ||
                          (idle_plan == IDLE_BOTH && $urandom_range(0, 99) < 21));
      end
    end
  end

  // Watchdog on progress
  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.func          = '0;
    req_ch.mode_first    = '0;
    req_ch.value_first   = '0;
    req_ch.mode_second   = '0;
    req_ch.value_second  = '0;
    rsp_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.start_address = '0;
    idle_plan            = IDLE_NONE;
    long_hold_phase      = 1'b0;
    mismatches           = 0;
    instrs_sent          = 0;
    status_seen          = 0;
    cfg_writes           = 0;
    quiet_cycles         = 0;
    foreach (vm_regs[i]) vm_regs[i] = '0;
    foreach (vm_stack[i]) vm_stack[i] = '0;
    foreach (vm_heap[i]) vm_heap[i] = '0;

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: field extremes, every opcode but NOP and HALT, index wrap, spare opcodes
    write_start(16'hFFFF);
    pending_instrs.push_back(make_instr(FN_ADD, MD_DIRECT, 16'h7FFF, MD_DIRECT, 16'h0001));
    pending_instrs.push_back(make_instr(FN_SUB, MD_DIRECT, 16'h8000, MD_DIRECT, 16'h0001));
    pending_instrs.push_back(make_instr(FN_MULT, 3'd7, 16'hFFFF, 3'd5, 16'hFFFF));
    pending_instrs.push_back(make_instr(FN_CMP, MD_DIRECT, 16'h1234, 3'd6, 16'h1234));
    pending_instrs.push_back(make_instr(FN_MOV, MD_HEAP, 16'h0105, MD_DIRECT, 16'hBEEF));
    pending_instrs.push_back(make_instr(FN_MOV, MD_REG, 16'hFFF8, MD_HEAP, 16'h0005));
    pending_instrs.push_back(make_instr(FN_MOV, MD_FRAME, 16'hFFFF, MD_REG, 16'hFFF3));
    pending_instrs.push_back(make_instr(FN_MOV, MD_SP, 16'h0002, MD_FRAME, 16'hFFFF));
    pending_instrs.push_back(make_instr(FN_MOV, MD_DIRECT, 16'h0003, MD_SP, 16'h0002));
    pending_instrs.push_back(make_instr(FN_MOV, 3'd7, 16'h0003, MD_DIRECT, 16'h5555));
    pending_instrs.push_back(make_instr(FN_MOV, MD_REG, 16'h0000, MD_DIRECT, 16'h0040));
    pending_instrs.push_back(make_instr(FN_JMP, MD_DIRECT, 16'hFFF0, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_JMP, MD_HEAP, 16'h0100, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_JNZ, MD_REG, 16'h0020, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_JZ, MD_DIRECT, 16'h0020, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_PUSH, MD_DIRECT, 16'hA5A5, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_CALL, MD_DIRECT, 16'h0100, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_PUSH, MD_FRAME, 16'hFFFE, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_RET, MD_DIRECT, 16'h0, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_POP, MD_DIRECT, 16'h0, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_SUB, MD_DIRECT, 16'h0, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_JZ, MD_SP, 16'h0003, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_JNZ, MD_DIRECT, 16'h0003, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FnSpare14, MD_DIRECT, 16'h0, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FnSpare15, MD_DIRECT, 16'h0, MD_DIRECT, 16'h0));

    // Random phases, one idle plan each, start address changed between them
    queue_random_phase(PhaseItems);
    write_start(16'h0000);
    idle_plan = IDLE_SENDER;
    queue_random_phase(PhaseItems);
    write_start(16'($urandom));
    idle_plan = IDLE_RECEIVER;
    long_hold_phase = 1'b1;
    queue_random_phase(PhaseItems);
    write_start(16'h8000);
    idle_plan = IDLE_BOTH;
    queue_random_phase(PhaseItems);

    // Halt, then instructions that must leave the state untouched
    pending_instrs.push_back(make_instr(FN_HALT, MD_DIRECT, 16'h0, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_ADD, MD_DIRECT, 16'h0011, MD_DIRECT, 16'h0022));
    pending_instrs.push_back(make_instr(FN_JMP, MD_DIRECT, 16'h0100, MD_DIRECT, 16'h0));
    pending_instrs.push_back(make_instr(FN_PUSH, MD_DIRECT, 16'h0001, MD_DIRECT, 16'h0));
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("ran %0d instructions, checked %0d responses", instrs_sent, status_seen);
    $display("covered %0d start address writes, four idle plans, a long stall and halt",
             cfg_writes);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, expected_status.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/svie_pkg.sv
design/svie_if.sv
design/svie_alu.sv
design/stack_vm_instruction_execute.sv
design/svie_checker.sv
tb/sv/testbench.sv
